>>> design/i2a_pkg.sv
package i2a_pkg;

  typedef logic [3:0] nibble_t;
  typedef logic [6:0] char_t;

  // ASCII of '0' and the offset that maps 10..15 onto 'A'..'F'
  localparam char_t CH_ZERO   = 7'h30;
  localparam char_t CH_LETTER = 7'h37;
  localparam nibble_t DEC_LIMIT = 4'd10;
  localparam nibble_t DD_THRESH = 4'd5;
  localparam nibble_t DD_ADJUST = 4'd3;

  function automatic char_t digit_ascii(input nibble_t d);
    char_t c;
    if (d < DEC_LIMIT) begin
      c = CH_ZERO + char_t'(d);
    end else begin
      c = CH_LETTER + char_t'(d);
    end
    return c;
  endfunction

endpackage

>>> design/i2a_dd_stage.sv
module i2a_dd_stage #(
  parameter int VW = 32,
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic          in_hex,
  input  logic [VW-1:0] in_val,
  input  logic [DW-1:0] in_bcd,
  output logic          out_vld,
  output logic          out_hex,
  output logic [VW-1:0] out_val,
  output logic [DW-1:0] out_bcd
);

  logic [DW-1:0] adj;
  logic          vld_r;
  logic          hex_r;
  logic [VW-1:0] val_r;
  logic [DW-1:0] bcd_r;

  // add-3 correction per BCD digit; hex just shifts the binary in
  always_comb begin
    adj = in_bcd;
    for (int i = 0; i < DW / 4; i++) begin
      if (!in_hex && (in_bcd[4*i +: 4] >= i2a_pkg::DD_THRESH)) begin
        adj[4*i +: 4] = in_bcd[4*i +: 4] + i2a_pkg::DD_ADJUST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hex_r <= in_hex;
      val_r <= {in_val[VW-2:0], 1'b0};
      bcd_r <= {adj[DW-2:0], in_val[VW-1]};
    end
  end

  assign out_vld = vld_r;
  assign out_hex = hex_r;
  assign out_val = val_r;
  assign out_bcd = bcd_r;

endmodule

>>> design/i2a_emit.sv
module i2a_emit #(
  parameter int DIGITS = 10,
  parameter int CW     = 4,
  parameter int IW     = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic [4*DIGITS-1:0] load_dig,
  input  logic [CW-1:0]       load_cnt,
  output logic                busy,
  output logic                out_valid,
  output i2a_pkg::char_t      out_char,
  output logic                out_last
);

  logic [4*DIGITS-1:0] buf_r;
  logic [CW-1:0]       left_r;
  logic [CW-1:0]       left_nxt;
  logic [CW-1:0]       pos;
  logic [IW-1:0]       idx;

  // countdown of characters still to send, most significant first
  always_comb begin
    left_nxt = left_r;
    if (load) begin
      left_nxt = load_cnt;
    end else if (left_r != '0) begin
      left_nxt = left_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= load_dig;
    end
  end

  assign pos       = left_r - CW'(1);
  assign idx       = pos[IW-1:0];
  assign out_valid = (left_r != '0);
  assign out_last  = (left_r == CW'(1));
  assign out_char  = i2a_pkg::digit_ascii(buf_r[4*idx +: 4]);
  assign busy      = (left_r > CW'(1));

endmodule

>>> design/integer_to_ascii_digits_core.sv
// Unsigned binary to ASCII decimal / hex converter.
// Input: pulse start with in_value and in_use_hex while busy is low; the
// item is taken at that edge. use_hex=1 gives upper-case hex, else decimal.
// Output: one character per cycle on out_digit_char, marked by out_valid,
// most significant first, no leading zeros (zero gives a single '0').
// out_is_last flags the final character. Results are not held: the
// receiver must take each one in the cycle it is shown.
// An accepted item passes VALUE_BITS double-dabble stages (one bit
// each), then the count register, then the emitter countdown register.
// Throughput: an item may enter every cycle while the pipeline flows;
// the output port sends one character a cycle, so an item with N digits
// (up to 10 at 32 bits) holds the emitter until its last character, and
// busy rises while a finished item waits on the emitter.
// Reset (synchronous, rst_n low) clears all valid bits and the emitter
// countdown; items in flight are dropped.
module integer_to_ascii_digits_core #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  in_use_hex,
  output logic                  out_valid,
  output logic [6:0]            out_digit_char,
  output logic                  out_is_last
);

  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DW     = 4 * DIGITS;
  localparam int CW     = $clog2(DIGITS + 1);
  localparam int IW     = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic                  adv;
  logic                  emit_busy;
  logic                  s_vld [VALUE_BITS+1];
  logic                  s_hex [VALUE_BITS+1];
  logic [VALUE_BITS-1:0] s_val [VALUE_BITS+1];
  logic [DW-1:0]         s_bcd [VALUE_BITS+1];
  logic                  cnt_vld_r;
  logic [DW-1:0]         dig_r;
  logic [CW-1:0]         ndig_r;
  logic [CW-1:0]         ndig_nxt;

  // whole pipe holds while a finished item waits on the emitter
  assign adv  = !(cnt_vld_r && emit_busy);
  assign busy = !adv;

  assign s_vld[0] = start;
  assign s_hex[0] = in_use_hex;
  assign s_val[0] = in_value;
  assign s_bcd[0] = '0;

  // one double-dabble step per stage
  for (genvar g = 0; g < VALUE_BITS; g++) begin : g_dd
    i2a_dd_stage #(.VW(VALUE_BITS), .DW(DW)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .in_vld (s_vld[g]),
      .in_hex (s_hex[g]),
      .in_val (s_val[g]),
      .in_bcd (s_bcd[g]),
      .out_vld(s_vld[g+1]),
      .out_hex(s_hex[g+1]),
      .out_val(s_val[g+1]),
      .out_bcd(s_bcd[g+1])
    );
  end

  // digit count: highest nonzero digit, at least one
  always_comb begin
    ndig_nxt = CW'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (s_bcd[VALUE_BITS][4*i +: 4] != '0) begin
        ndig_nxt = CW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= 1'b0;
    end else if (adv) begin
      cnt_vld_r <= s_vld[VALUE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dig_r  <= s_bcd[VALUE_BITS];
      ndig_r <= ndig_nxt;
    end
  end

  i2a_emit #(.DIGITS(DIGITS), .CW(CW), .IW(IW)) u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cnt_vld_r && adv),
    .load_dig (dig_r),
    .load_cnt (ndig_r),
    .busy     (emit_busy),
    .out_valid(out_valid),
    .out_char (out_digit_char),
    .out_last (out_is_last)
  );

`ifndef NO_ASSERTIONS
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |=> out_valid)
    else $error("character run broken before last");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_digit_char >= 7'h30) && (out_digit_char <= 7'h39)) ||
                  ((out_digit_char >= 7'h41) && (out_digit_char <= 7'h46)))
    else $error("illegal digit character");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> cnt_vld_r && out_valid && !out_is_last)
    else $error("stall without pending output");
`endif

endmodule
